### rtl/bfec_pkg.sv
// shared constants and payload types of the brainfuck execute core
// no dependencies; compiled first
package bfec_pkg;

  localparam int unsigned DEFAULT_TAPE_DEPTH = 4096;
  localparam int unsigned DEFAULT_LOOP_DEPTH = 256;
  localparam int unsigned PROGRAM_DEPTH      = 65536;

  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned START_CELL_W = 12;
  localparam int unsigned SKIP_W       = 16;

  // command characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_PAST_END    = 3'd1;
  localparam logic [2:0] ST_BEFORE_START = 3'd2;
  localparam logic [2:0] ST_OPEN_UNMATCH = 3'd3;
  localparam logic [2:0] ST_CLOSE_UNMATCH = 3'd4;
  localparam logic [2:0] ST_UNKNOWN     = 3'd5;
  localparam logic [2:0] ST_STACK_FULL  = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] instr_addr;
    logic [7:0]        instr_byte;
    logic [7:0]        input_byte;
    logic              program_end;
  } instr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_addr;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              input_used;
    logic [2:0]        status;
    logic              halted;
  } result_t;

endpackage

### rtl/bfec_if.sv
// valid/ready channel interfaces for instruction and result transactions
// depends on bfec_pkg
interface bfec_instr_if;
  import bfec_pkg::*;

  logic   valid;
  logic   ready;
  instr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfec_result_if;
  import bfec_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/brainfuck_execute_core_top.sv
// brainfuck execute core: tape and loop stack memories, execute logic, result register
// depends on bfec_pkg and the channel interfaces in bfec_if.sv
//
// Usage: the host sends one instruction transaction per program byte on instr_i
// (address, byte, input byte for ',', program end flag) and gets one result
// transaction on result_o carrying the next address to fetch, any '.' output,
// the input-consumed flag, a status code and the halted flag.
// start_cell is written via cfg_we_i / cfg_wdata_i, by the user only while the core is
// idle (unenforced); a write places the head there (clamped to the last cell).
// Throughput is one instruction per cycle unless the output register is full and not
// taken or the tape is being cleared: the current cell and the top of the loop stack
// are read every cycle at the address the executing instruction leaves behind, and a
// write to that same entry is forwarded, so back-to-back '+' / '-' / ',' and '[' / ']'
// need no stall. An accepted instruction's result enters the output register in the
// next cycle. When result_o stalls, instr_i still accepts in the cycle the result is
// taken; with a full output register and no ready, instr_i.ready is low.
// After reset the tape is cleared one cell a cycle over all TAPE_DEPTH cells (4096 by
// default), and instr_i.ready stays low until the clearing pass is done.
module brainfuck_execute_core_top #(
  parameter int unsigned TAPE_DEPTH = bfec_pkg::DEFAULT_TAPE_DEPTH,
  parameter int unsigned LOOP_DEPTH = bfec_pkg::DEFAULT_LOOP_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfec_pkg::START_CELL_W-1:0] cfg_wdata_i,
  bfec_instr_if.sink                        instr_i,
  bfec_result_if.source                     result_o
);
  import bfec_pkg::*;

  localparam int unsigned HW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int unsigned IW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LOOP_DEPTH + 1);
  localparam logic [HW-1:0] LAST_CELL = HW'(TAPE_DEPTH - 1);

  // memories
  logic [7:0]        tape_mem [TAPE_DEPTH];
  logic [ADDR_W-1:0] stack_mem [LOOP_DEPTH];

  // control state
  logic [HW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic              stop_q, stop_d;
  logic              clear_q;
  logic [HW-1:0]     clr_cnt_q;
  logic              out_valid_q;
  result_t           out_data_q;
  result_t           res;

  // tape port
  logic              tape_we;
  logic [HW-1:0]     tape_waddr;
  logic [7:0]        tape_wdata;
  logic [7:0]        tape_rd_q;
  logic              tfwd_q;
  logic [7:0]        twdata_q;
  logic [7:0]        cur_cell;
  logic              cell_we;
  logic [7:0]        cell_new;

  // stack port
  logic              push;
  logic [IW-1:0]     push_idx;
  logic [ADDR_W-1:0] push_data;
  logic [CW-1:0]     cnt_dec;
  logic [IW-1:0]     stk_raddr;
  logic [ADDR_W-1:0] stk_rd_q;
  logic              sfwd_q;
  logic [ADDR_W-1:0] swdata_q;
  logic [ADDR_W-1:0] top;

  logic              accept;
  logic [ADDR_W:0]   addr_inc;
  logic [ADDR_W-1:0] addr_next;

  assign instr_i.ready = !clear_q && (!out_valid_q || result_o.ready);
  assign accept        = instr_i.valid && instr_i.ready;

  assign cur_cell = tfwd_q ? twdata_q : tape_rd_q;
  assign top      = sfwd_q ? swdata_q : stk_rd_q;

  assign addr_inc  = {1'b0, instr_i.data.instr_addr} + 1'b1;
  assign addr_next = (32'(addr_inc) >= PROGRAM_DEPTH) ? '0 : addr_inc[ADDR_W-1:0];
  assign push_idx  = cnt_q[IW-1:0];

  always_comb begin
    head_d    = head_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    stop_d    = stop_q;
    cell_we   = 1'b0;
    cell_new  = cur_cell;
    push      = 1'b0;
    push_data = addr_next;
    res       = '0;
    res.next_addr = addr_next;

    if (accept) begin
      if (stop_q) begin
        res.next_addr = instr_i.data.instr_addr;
      end else if (instr_i.data.program_end) begin
        if (skip_q != '0) begin
          res.status = ST_OPEN_UNMATCH;
        end
        stop_d        = 1'b1;
        res.next_addr = instr_i.data.instr_addr;
      end else if (skip_q != '0) begin
        // inside a skipped loop only brackets count
        if (instr_i.data.instr_byte == CH_OPEN) begin
          if (skip_q != '1) begin
            skip_d = skip_q + 1'b1;
          end
        end else if (instr_i.data.instr_byte == CH_CLOSE) begin
          skip_d = skip_q - 1'b1;
        end
      end else begin
        case (instr_i.data.instr_byte) inside
          CH_PLUS: begin
            cell_we  = 1'b1;
            cell_new = cur_cell + 8'd1;
          end
          CH_MINUS: begin
            cell_we  = 1'b1;
            cell_new = cur_cell - 8'd1;
          end
          CH_RIGHT: begin
            if (head_q == LAST_CELL) begin
              res.status    = ST_PAST_END;
              stop_d        = 1'b1;
              res.next_addr = instr_i.data.instr_addr;
            end else begin
              head_d = head_q + 1'b1;
            end
          end
          CH_LEFT: begin
            if (head_q == '0) begin
              res.status    = ST_BEFORE_START;
              stop_d        = 1'b1;
              res.next_addr = instr_i.data.instr_addr;
            end else begin
              head_d = head_q - 1'b1;
            end
          end
          CH_DOT: begin
            res.out_valid = 1'b1;
            res.out_byte  = cur_cell;
          end
          CH_COMMA: begin
            res.input_used = 1'b1;
            cell_we        = 1'b1;
            cell_new       = instr_i.data.input_byte;
          end
          CH_OPEN: begin
            if (cur_cell == 8'd0) begin
              skip_d = SKIP_W'(1);
            end else if (32'(cnt_q) >= LOOP_DEPTH) begin
              res.status    = ST_STACK_FULL;
              stop_d        = 1'b1;
              res.next_addr = instr_i.data.instr_addr;
            end else begin
              push  = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
          end
          CH_CLOSE: begin
            if (cnt_q == '0) begin
              res.status    = ST_CLOSE_UNMATCH;
              stop_d        = 1'b1;
              res.next_addr = instr_i.data.instr_addr;
            end else if (cur_cell != 8'd0) begin
              res.next_addr = top;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
          CH_SPACE, CH_SLASH, CH_LF, CH_TAB, CH_CR: begin
          end
          default: begin
            res.status = ST_UNKNOWN;
          end
        endcase
      end
    end

    res.halted = stop_d;

    if (cfg_we_i) begin
      if (32'(cfg_wdata_i) >= TAPE_DEPTH) begin
        head_d = LAST_CELL;
      end else begin
        head_d = HW'(cfg_wdata_i);
      end
    end
  end

  // tape port: clearing pass has priority, no instruction is taken meanwhile
  assign tape_we    = clear_q || cell_we;
  assign tape_waddr = clear_q ? clr_cnt_q : head_q;
  assign tape_wdata = clear_q ? 8'd0 : cell_new;

  // top of stack after this cycle
  assign cnt_dec   = cnt_d - 1'b1;
  assign stk_raddr = cnt_dec[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    tape_rd_q <= tape_mem[head_d];
    twdata_q  <= tape_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[push_idx] <= push_data;
    end
    stk_rd_q <= stack_mem[stk_raddr];
    swdata_q <= push_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      skip_q      <= '0;
      stop_q      <= 1'b0;
      clear_q     <= 1'b1;
      clr_cnt_q   <= '0;
      tfwd_q      <= 1'b0;
      sfwd_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
      stop_q <= stop_d;
      tfwd_q <= tape_we && (tape_waddr == head_d);
      sfwd_q <= push && (push_idx == stk_raddr);
      if (clear_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_CELL) begin
          clear_q <= 1'b0;
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clear_q |-> !accept)
    else $error("instruction accepted during tape clearing");

  a_stack_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni) 32'(cnt_q) <= LOOP_DEPTH)
    else $error("loop stack count beyond depth");

  a_stop_sticks: assert property (
    @(posedge clk_i) disable iff (!rst_ni) stop_q |=> stop_q)
    else $error("stopped flag cleared without reset");

  a_push_counts: assert property (
    @(posedge clk_i) disable iff (!rst_ni) push |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not advance the stack count");

  a_halted_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && stop_d) |=> (result_o.valid && result_o.data.halted))
    else $error("halting transaction not reported as halted");
`endif

endmodule

### tb/sv/brainfuck_execute_core_top_tb.sv
// self-checking testbench for brainfuck_execute_core_top: acts as the program host,
// predicts every result transaction and checks it field by field
// depends on bfec_pkg, bfec_if.sv and the rtl top level
`timescale 1ns / 100ps

module brainfuck_execute_core_top_tb;
  import bfec_pkg::*;

  localparam int unsigned SKIP_MAX = (1 << SKIP_W) - 1;

  class bf_exec_scoreboard;
    logic [7:0]  tape [DEFAULT_TAPE_DEPTH];
    logic [15:0] ret_stack [DEFAULT_LOOP_DEPTH];
    int unsigned head;
    int unsigned loop_count;
    int unsigned skip_depth;
    bit          stopped;
    logic [11:0] start_cell;
    logic [15:0] last_next;
    int unsigned err_count;
    result_t     pending_results[$];

    function new();
      foreach (tape[i]) tape[i] = 8'h00;
      head       = 0;
      loop_count = 0;
      skip_depth = 0;
      stopped    = 0;
      start_cell = '0;
      last_next  = '0;
      err_count  = 0;
    endfunction

    function void set_start(logic [11:0] v);
      start_cell = v;
      head = (v >= DEFAULT_TAPE_DEPTH) ? DEFAULT_TAPE_DEPTH - 1 : v;
    endfunction

    // true when executing this transaction would stop the core
    function bit would_halt(instr_t it);
      if (stopped) return 1'b0;
      if (it.program_end) return 1'b1;
      if (skip_depth != 0) return 1'b0;
      case (it.instr_byte)
        CH_RIGHT: return head + 1 >= DEFAULT_TAPE_DEPTH;
        CH_LEFT:  return head == 0;
        CH_OPEN:  return tape[head] != 0 && loop_count >= DEFAULT_LOOP_DEPTH;
        CH_CLOSE: return loop_count == 0;
        default:  return 1'b0;
      endcase
    endfunction

    function result_t exec_instr(instr_t it);
      result_t     r;
      int unsigned n;
      logic [15:0] nxt;
      r = '0;
      n = it.instr_addr + 1;
      if (n >= PROGRAM_DEPTH) n = 0;
      nxt = n[15:0];
      if (stopped) begin
        nxt = it.instr_addr;
      end else if (it.program_end) begin
        if (skip_depth != 0) r.status = ST_OPEN_UNMATCH;
        stopped = 1'b1;
        nxt = it.instr_addr;
      end else if (skip_depth != 0) begin
        // only brackets count while skipping
        if (it.instr_byte == CH_OPEN) begin
          if (skip_depth < SKIP_MAX) skip_depth++;
        end else if (it.instr_byte == CH_CLOSE) begin
          skip_depth--;
        end
      end else begin
        case (it.instr_byte)
          CH_PLUS:  tape[head] = tape[head] + 8'd1;
          CH_MINUS: tape[head] = tape[head] - 8'd1;
          CH_RIGHT: begin
            if (head + 1 >= DEFAULT_TAPE_DEPTH) begin
              r.status = ST_PAST_END;
              stopped = 1'b1;
              nxt = it.instr_addr;
            end else begin
              head++;
            end
          end
          CH_LEFT: begin
            if (head == 0) begin
              r.status = ST_BEFORE_START;
              stopped = 1'b1;
              nxt = it.instr_addr;
            end else begin
              head--;
            end
          end
          CH_DOT: begin
            r.out_valid = 1'b1;
            r.out_byte  = tape[head];
          end
          CH_COMMA: begin
            r.input_used = 1'b1;
            tape[head] = it.input_byte;
          end
          CH_OPEN: begin
            if (tape[head] == 0) begin
              skip_depth = 1;
            end else if (loop_count >= DEFAULT_LOOP_DEPTH) begin
              r.status = ST_STACK_FULL;
              stopped = 1'b1;
              nxt = it.instr_addr;
            end else begin
              ret_stack[loop_count] = nxt;
              loop_count++;
            end
          end
          CH_CLOSE: begin
            if (loop_count == 0) begin
              r.status = ST_CLOSE_UNMATCH;
              stopped = 1'b1;
              nxt = it.instr_addr;
            end else if (tape[head] != 0) begin
              nxt = ret_stack[loop_count - 1];
            end else begin
              loop_count--;
            end
          end
          CH_SPACE, CH_SLASH, CH_LF, CH_TAB, CH_CR: ;
          default: r.status = ST_UNKNOWN;
        endcase
      end
      r.next_addr = nxt;
      r.halted    = stopped;
      return r;
    endfunction

    function void note_instr(instr_t it);
      result_t r;
      r = exec_instr(it);
      last_next = r.next_addr;
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        err_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %h", $time, got);
        err_count++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("next_addr", want.next_addr, got.next_addr);
      cmp_field("out_valid", want.out_valid, got.out_valid);
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("input_used", want.input_used, got.input_used);
      cmp_field("status", want.status, got.status);
      cmp_field("halted", want.halted, got.halted);
    endfunction
  endclass

  typedef enum {
    HALT_PROG_END, HALT_OPEN_SKIP, HALT_PAST_END,
    HALT_BEFORE_START, HALT_CLOSE_EMPTY, HALT_STACK_FULL
  } halt_kind_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [11:0] cfg_wdata;

  bfec_instr_if  instr_ch ();
  bfec_result_if result_ch ();

  bf_exec_scoreboard sb = new();

  logic [7:0]  prog_mem [64];
  logic [15:0] pc;
  int          burst_pct   = 0;
  bit          quiet       = 0;
  int          taken_count = 0;

  brainfuck_execute_core_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .instr_i     (instr_ch),
    .result_o    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      sb.check_result(result_ch.data);
      taken_count++;
    end
  end

  // result side: random stalls, one long hold-off to back the core up
  initial begin : result_sink
    int hold_n;
    bit long_done;
    long_done = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && !long_done && taken_count >= 200) begin
        long_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if ($urandom_range(0, 99) < burst_pct) begin
        hold_n = $urandom_range(1, 10);
        result_ch.ready <= 1'b0;
        repeat (hold_n - 1) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(instr_t it);
    int gap;
    if ($urandom_range(0, 99) < burst_pct) begin
      gap = $urandom_range(1, 10);
      instr_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.data  <= it;
    @(posedge clk);
    while (instr_ch.ready !== 1'b1) @(posedge clk);
    sb.note_instr(it);
    @(negedge clk);
  endtask

  // fetch at the predicted address, like the host would
  task automatic exec_cmd(logic [7:0] b, logic [7:0] inb, bit pend);
    instr_t it;
    it.instr_addr  = pc;
    it.instr_byte  = b;
    it.input_byte  = inb;
    it.program_end = pend;
    send_item(it);
    pc = sb.last_next;
  endtask

  task automatic write_start(logic [11:0] v);
    instr_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_start(v);
  endtask

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 19))
      0, 1, 2, 19: return CH_PLUS;
      3, 4:        return CH_MINUS;
      5, 6:        return CH_RIGHT;
      7, 8:        return CH_LEFT;
      9, 10:       return CH_DOT;
      11, 12:      return CH_COMMA;
      13, 14:      return CH_OPEN;
      15, 16:      return CH_CLOSE;
      17: begin
        case ($urandom_range(0, 4))
          0:       return CH_SPACE;
          1:       return CH_SLASH;
          2:       return CH_LF;
          3:       return CH_TAB;
          default: return CH_CR;
        endcase
      end
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly small random programs fetched along the predicted flow, some noise
  task automatic random_phase(int n);
    instr_t it;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) burst_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (i == 0 || $urandom_range(0, 99) < 2) begin
        pc = 16'($urandom);
        foreach (prog_mem[j]) prog_mem[j] = pick_cmd();
      end
      if ($urandom_range(0, 7) == 0) begin
        it.instr_addr = 16'($urandom);
        it.instr_byte = 8'($urandom_range(0, 255));
      end else begin
        it.instr_addr = pc;
        it.instr_byte = prog_mem[pc[5:0]];
      end
      it.input_byte  = 8'($urandom_range(0, 255));
      it.program_end = 1'b0;
      if (sb.would_halt(it)) it.instr_byte = CH_DOT;
      send_item(it);
      pc = sb.last_next;
    end
  endtask

  // deeply nested skip and back out, stray bytes mixed in
  task automatic skip_nesting();
    while (sb.skip_depth != 0) exec_cmd(CH_CLOSE, 8'h00, 1'b0);
    exec_cmd(CH_COMMA, 8'h00, 1'b0);
    exec_cmd(CH_OPEN, 8'h00, 1'b0);
    while (sb.skip_depth < 40) begin
      if ($urandom_range(0, 7) == 0) exec_cmd(8'($urandom_range(0, 255)), 8'h00, 1'b0);
      else exec_cmd(CH_OPEN, 8'h00, 1'b0);
    end
    repeat (4) exec_cmd(CH_OPEN, 8'h00, 1'b0);
    while (sb.skip_depth != 0) begin
      if ($urandom_range(0, 7) == 0) exec_cmd(8'($urandom_range(0, 255)), 8'h00, 1'b0);
      else exec_cmd(CH_CLOSE, 8'h00, 1'b0);
    end
    exec_cmd(CH_DOT, 8'h00, 1'b0);
  endtask

  // one way of stopping the core, picked by the seed
  task automatic halt_block();
    halt_kind_e kind;
    kind = halt_kind_e'($urandom_range(0, 5));
    case (kind)
      HALT_PROG_END: exec_cmd(CH_DOT, 8'h00, 1'b1);
      HALT_OPEN_SKIP: begin
        exec_cmd(CH_COMMA, 8'h00, 1'b0);
        exec_cmd(CH_OPEN, 8'h00, 1'b0);
        exec_cmd(CH_PLUS, 8'h00, 1'b1);
      end
      HALT_PAST_END: begin
        write_start(12'hFFF);
        exec_cmd(CH_RIGHT, 8'h00, 1'b0);
      end
      HALT_BEFORE_START: begin
        write_start(12'h000);
        exec_cmd(CH_LEFT, 8'h00, 1'b0);
      end
      HALT_CLOSE_EMPTY: begin
        exec_cmd(CH_COMMA, 8'h00, 1'b0);
        while (sb.loop_count != 0) exec_cmd(CH_CLOSE, 8'h00, 1'b0);
        exec_cmd(CH_CLOSE, 8'h00, 1'b0);
      end
      default: begin
        if (sb.tape[sb.head] == 0) exec_cmd(CH_PLUS, 8'h00, 1'b0);
        while (sb.loop_count < DEFAULT_LOOP_DEPTH) exec_cmd(CH_OPEN, 8'h00, 1'b0);
        exec_cmd(CH_OPEN, 8'h00, 1'b0);
      end
    endcase
  endtask

  initial begin : stimulus
    instr_t it;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    instr_ch.valid = 1'b0;
    instr_ch.data  = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    burst_pct = 25;

    // directed: wrap of address and cell, i/o, head moves, skip, loop, no-ops
    pc = 16'hFFFF;
    exec_cmd(CH_PLUS, 8'h00, 1'b0);
    exec_cmd(CH_MINUS, 8'h00, 1'b0);
    exec_cmd(CH_MINUS, 8'h00, 1'b0);
    exec_cmd(CH_PLUS, 8'h00, 1'b0);
    exec_cmd(CH_COMMA, 8'hFF, 1'b0);
    exec_cmd(CH_DOT, 8'h00, 1'b0);
    exec_cmd(CH_COMMA, 8'h00, 1'b0);
    exec_cmd(CH_DOT, 8'hFF, 1'b0);
    exec_cmd(CH_RIGHT, 8'h00, 1'b0);
    exec_cmd(CH_PLUS, 8'h00, 1'b0);
    exec_cmd(CH_DOT, 8'h00, 1'b0);
    exec_cmd(CH_LEFT, 8'h00, 1'b0);
    exec_cmd(CH_OPEN, 8'h00, 1'b0);
    exec_cmd(CH_PLUS, 8'h00, 1'b0);
    exec_cmd(CH_OPEN, 8'h00, 1'b0);
    exec_cmd(8'h78, 8'h00, 1'b0);
    exec_cmd(CH_CLOSE, 8'h00, 1'b0);
    exec_cmd(CH_CLOSE, 8'h00, 1'b0);
    exec_cmd(CH_COMMA, 8'hA5, 1'b0);
    exec_cmd(CH_OPEN, 8'h00, 1'b0);
    exec_cmd(CH_MINUS, 8'h00, 1'b0);
    exec_cmd(CH_CLOSE, 8'h00, 1'b0);
    exec_cmd(CH_COMMA, 8'h00, 1'b0);
    exec_cmd(CH_CLOSE, 8'h00, 1'b0);
    exec_cmd(8'h78, 8'h00, 1'b0);
    exec_cmd(CH_SPACE, 8'h00, 1'b0);
    exec_cmd(CH_SLASH, 8'h00, 1'b0);
    exec_cmd(CH_LF, 8'h00, 1'b0);
    exec_cmd(CH_TAB, 8'h00, 1'b0);
    exec_cmd(CH_CR, 8'h00, 1'b0);

    write_start(12'hFFF);
    random_phase(450);
    write_start(12'($urandom_range(1, 4094)));
    random_phase(450);
    write_start(12'h000);
    random_phase(500);

    // no random gaps or stalls from here on
    quiet     = 1'b1;
    burst_pct = 0;
    skip_nesting();
    halt_block();

    for (int i = 0; i < 16; i++) begin
      it.instr_addr  = 16'($urandom);
      it.instr_byte  = 8'($urandom_range(0, 255));
      it.input_byte  = 8'($urandom_range(0, 255));
      it.program_end = (i == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      send_item(it);
    end

    instr_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
